// File: hw/rtl/ksq_pkg.sv
// Shared widths and the command/status bundles between controller and datapath.
package ksq_pkg;

	localparam int VALUE_W = 32;
	localparam int RANK_W  = 10;

	typedef struct packed {
		logic load;
		logic start;
		logic piv_rd;
		logic piv_ld;
		logic scan_rd;
		logic wr_s;
		logic wr_b;
		logic wr_a;
		logic advance;
		logic narrow;
		logic emit;
	} ksq_cmd_t;

	typedef struct packed {
		logic rank_bad;
		logic scan_done;
		logic elem_less;
		logic elem_greater;
		logic found;
		logic out_busy;
	} ksq_sts_t;

endpackage

// File: hw/rtl/ksq_intf.sv
// Valid/ready channel interfaces for the element input and the result output.
interface ksq_in_if import ksq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  value;
	logic                       first;
	logic                       last;
	logic        [RANK_W-1:0]   rank;

	modport source (output valid, output value, output first, output last, output rank,
		input ready);
	modport sink (input valid, input value, input first, input last, input rank,
		output ready);
endinterface

interface ksq_out_if import ksq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  selected;
	logic                       rank_error;
	logic                       overflow;

	modport source (output valid, output selected, output rank_error, output overflow,
		input ready);
	modport sink (input valid, input selected, input rank_error, input overflow,
		output ready);
endinterface

// File: hw/rtl/ksq_datapath.sv
// Element store, partition pointers, pivot and result register.
module ksq_datapath import ksq_pkg::*; #(
	parameter int STORE_DEPTH = 1024,
	parameter int DATA_WIDTH  = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ksq_cmd_t                   cmd,
	output ksq_sts_t                   sts,
	input  logic signed [VALUE_W-1:0]  in_value,
	input  logic                       in_first,
	input  logic        [RANK_W-1:0]   in_rank,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic signed [VALUE_W-1:0]  res_selected,
	output logic                       res_rank_error,
	output logic                       res_overflow
);

	localparam int AW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW   = $clog2(STORE_DEPTH + 1);
	localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

	logic signed [DATA_WIDTH-1:0] mem [STORE_DEPTH];

	logic        [CW-1:0]         count_q;
	logic                         ovf_q;
	logic        [CW-1:0]         wl_q;
	logic        [CW-1:0]         wh_q;
	logic        [CW-1:0]         eq_q;
	logic        [CW-1:0]         gt_q;
	logic        [CW-1:0]         sp_q;
	logic        [RANK_W-1:0]     tr_q;
	logic                         err_q;
	logic signed [DATA_WIDTH-1:0] pivot_q;
	logic signed [DATA_WIDTH-1:0] rd_a_q;
	logic signed [DATA_WIDTH-1:0] rd_b_q;
	logic                         out_valid_q;
	logic signed [VALUE_W-1:0]    sel_q;
	logic                         rerr_q;
	logic                         rovf_q;

	logic                         full;
	logic                         we;
	logic        [AW-1:0]         waddr;
	logic signed [DATA_WIDTH-1:0] wdata;
	logic                         ra_en;
	logic        [AW-1:0]         ra_addr;
	logic        [CMPW-1:0]       tr_ext;
	logic                         below_eq;
	logic                         at_or_past_gt;

	assign full          = (count_q >= CW'(STORE_DEPTH));
	assign tr_ext        = CMPW'(tr_q);
	assign below_eq      = (tr_ext < CMPW'(eq_q));
	assign at_or_past_gt = (tr_ext >= CMPW'(gt_q));

	assign sts.rank_bad     = (tr_ext >= CMPW'(count_q));
	assign sts.scan_done    = (sp_q >= wh_q);
	assign sts.elem_less    = (rd_a_q < pivot_q);
	assign sts.elem_greater = (rd_a_q > pivot_q);
	assign sts.found        = !below_eq && !at_or_past_gt;
	assign sts.out_busy     = out_valid_q && !res_ready;

	// One write port shared by loading and the three partition writes.
	always_comb begin
		we    = 1'b0;
		waddr = sp_q[AW-1:0];
		wdata = rd_b_q;
		priority if (cmd.load) begin
			we    = in_first || !full;
			waddr = in_first ? '0 : count_q[AW-1:0];
			wdata = DATA_WIDTH'(in_value);
		end else if (cmd.wr_s) begin
			we    = 1'b1;
			waddr = sp_q[AW-1:0];
			wdata = rd_b_q;
		end else if (cmd.wr_b) begin
			we    = 1'b1;
			waddr = gt_q[AW-1:0];
			wdata = pivot_q;
		end else if (cmd.wr_a) begin
			we    = 1'b1;
			waddr = eq_q[AW-1:0];
			wdata = rd_a_q;
		end else begin
			we    = 1'b0;
		end
	end

	assign ra_en   = cmd.piv_rd || cmd.scan_rd;
	assign ra_addr = cmd.piv_rd ? wl_q[AW-1:0] : sp_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ra_en) begin
			rd_a_q <= mem[ra_addr];
		end
		if (cmd.scan_rd) begin
			rd_b_q <= mem[gt_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			wl_q        <= '0;
			wh_q        <= '0;
			eq_q        <= '0;
			gt_q        <= '0;
			sp_q        <= '0;
			tr_q        <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				tr_q <= in_rank;
				priority if (in_first) begin
					count_q <= CW'(1);
					ovf_q   <= 1'b0;
				end else if (!full) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				wl_q  <= '0;
				wh_q  <= count_q;
				err_q <= sts.rank_bad;
			end
			if (cmd.piv_ld) begin
				eq_q <= wl_q;
				gt_q <= wl_q;
				sp_q <= wl_q;
			end
			if (cmd.wr_b) begin
				gt_q <= gt_q + CW'(1);
			end
			if (cmd.wr_a) begin
				eq_q <= eq_q + CW'(1);
			end
			if (cmd.advance) begin
				sp_q <= sp_q + CW'(1);
			end
			// Keep the side of the split that holds the rank.
			if (cmd.narrow) begin
				if (below_eq) begin
					wh_q <= eq_q;
				end else begin
					wl_q <= gt_q;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				ovf_q       <= 1'b0;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.piv_ld) begin
			pivot_q <= rd_a_q;
		end
		if (cmd.emit) begin
			sel_q  <= err_q ? '0 : VALUE_W'(pivot_q);
			rerr_q <= err_q;
			rovf_q <= ovf_q;
		end
	end

	assign res_valid      = out_valid_q;
	assign res_selected   = sel_q;
	assign res_rank_error = rerr_q;
	assign res_overflow   = rovf_q;

endmodule

// File: hw/rtl/ksq_ctrl.sv
// Sequencer for loading, partition passes and result hand-off.
module ksq_ctrl import ksq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  logic     item_last,
	output logic     item_ready,
	input  ksq_sts_t sts,
	output ksq_cmd_t cmd
);

	typedef enum logic [9:0] {
		ST_LOAD    = 10'b0000000001,
		ST_START   = 10'b0000000010,
		ST_PIV_RD  = 10'b0000000100,
		ST_PIV_LD  = 10'b0000001000,
		ST_SCAN_RD = 10'b0000010000,
		ST_SCAN_EV = 10'b0000100000,
		ST_WR_B    = 10'b0001000000,
		ST_WR_A    = 10'b0010000000,
		ST_NARROW  = 10'b0100000000,
		ST_DONE    = 10'b1000000000
	} ksq_state_t;

	ksq_state_t state_q;
	ksq_state_t state_d;

	assign item_ready = (state_q == ST_LOAD);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					if (item_last) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = sts.rank_bad ? ST_DONE : ST_PIV_RD;
			end
			ST_PIV_RD: begin
				cmd.piv_rd = 1'b1;
				state_d    = ST_PIV_LD;
			end
			ST_PIV_LD: begin
				cmd.piv_ld = 1'b1;
				state_d    = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				if (sts.scan_done) begin
					state_d = ST_NARROW;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = ST_SCAN_EV;
				end
			end
			ST_SCAN_EV: begin
				// Greater elements stay put; others rotate into place.
				if (sts.elem_greater) begin
					cmd.advance = 1'b1;
					state_d     = ST_SCAN_RD;
				end else begin
					cmd.wr_s = 1'b1;
					state_d  = ST_WR_B;
				end
			end
			ST_WR_B: begin
				cmd.wr_b = 1'b1;
				if (sts.elem_less) begin
					state_d = ST_WR_A;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_SCAN_RD;
				end
			end
			ST_WR_A: begin
				cmd.wr_a    = 1'b1;
				cmd.advance = 1'b1;
				state_d     = ST_SCAN_RD;
			end
			ST_NARROW: begin
				if (sts.found) begin
					state_d = ST_DONE;
				end else begin
					cmd.narrow = 1'b1;
					state_d    = ST_PIV_RD;
				end
			end
			ST_DONE: begin
				// Hold until the result register is free.
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/kth_smallest_quickselect_core.sv
// Rank selection over a stored set by three-way quickselect partitioning.
// Elements arrive one per transfer on item and are written into an on-chip store of
// STORE_DEPTH entries at one element per cycle; elements past the depth are dropped and
// the result reports overflow. The transfer with last set closes the set and supplies the
// rank; item is then held off while the selection runs, and one transfer on result follows.
// Each partition pass reads the pivot and then scans the window: an element above the pivot
// only advances the scan, one equal to it takes two writes and one below it takes three, set
// by the single write port of the store. Passes repeat on a shrinking window, quadratic in
// the count in the worst case. A rank at or past the count skips the passes and goes from the
// start state straight to the done state. A finished result waits in an output register, so
// loading of the next set proceeds while it is not yet taken.
module kth_smallest_quickselect_core import ksq_pkg::*; #(
	parameter int STORE_DEPTH = 1024,
	parameter int DATA_WIDTH  = 32
) (
	input logic       clk,
	input logic       arst_n,
	ksq_in_if.sink    item,
	ksq_out_if.source result
);

	ksq_cmd_t cmd;
	ksq_sts_t sts;

	ksq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_last  (item.last),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	ksq_datapath #(
		.STORE_DEPTH (STORE_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_value       (item.value),
		.in_first       (item.first),
		.in_rank        (item.rank),
		.res_valid      (result.valid),
		.res_ready      (result.ready),
		.res_selected   (result.selected),
		.res_rank_error (result.rank_error),
		.res_overflow   (result.overflow)
	);

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.emit))
		else $error("result valid rose without an emit");

	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_busy)
		else $error("result overwritten before its transfer");

	a_less_write_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_a |-> $past(cmd.wr_b))
		else $error("less-region write not preceded by pivot write");

endmodule
